// ===== hdl/clock_page_replacement_unit_macros.svh =====
// Assertion helpers used by the datapath RTL.
`ifndef CLOCK_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define CLOCK_PAGE_REPLACEMENT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CRPU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crpu check failed");

// Next-cycle implication, disabled during reset.
`define CRPU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crpu check failed");

`endif

// ===== hdl/crpu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package crpu_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  // Fixed port widths
  localparam int PAGE_PORT_W = 16;
  localparam int SLOT_PORT_W = 4;
  localparam int COUNT_W     = 32;
  localparam int CFG_W       = 5;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [CFG_W-1:0]   CFG_FRAMES_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;

  // Register index, taken from paddr[2]
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic sweep;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic hit_found;
    logic place_now;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/crpu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crpu_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire crpu_pkg::status_t status,
  output crpu_pkg::cmd_t        cmd
);

  crpu_pkg::state_t state;
  crpu_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crpu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      crpu_pkg::ST_IDLE: begin
        if (in_valid) state_next = crpu_pkg::ST_LOOKUP;
      end
      crpu_pkg::ST_LOOKUP: begin
        if (status.hit_found) state_next = crpu_pkg::ST_RESULT;
        else                  state_next = crpu_pkg::ST_SWEEP;
      end
      crpu_pkg::ST_SWEEP: begin
        if (status.place_now) state_next = crpu_pkg::ST_RESULT;
      end
      crpu_pkg::ST_RESULT: begin
        if (status.out_free) state_next = crpu_pkg::ST_IDLE;
      end
      default: state_next = crpu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state)
      crpu_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      crpu_pkg::ST_LOOKUP: cmd.lookup   = 1'b1;
      crpu_pkg::ST_SWEEP:  cmd.sweep    = 1'b1;
      crpu_pkg::ST_RESULT: cmd.load_out = status.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/crpu_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "clock_page_replacement_unit_macros.svh"
module crpu_datapath #(
  parameter int FRAMES    = crpu_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = crpu_pkg::PAGE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire crpu_pkg::cmd_t                    cmd,
  output crpu_pkg::status_t                      status,
  input  wire logic [crpu_pkg::CFG_W-1:0]        frames_in_use,
  input  wire logic [crpu_pkg::PAGE_PORT_W-1:0]  page_number,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   hit,
  output logic [crpu_pkg::SLOT_PORT_W-1:0]       frame_slot,
  output logic                                   evicted_valid,
  output logic [crpu_pkg::PAGE_PORT_W-1:0]       evicted_page,
  output logic [crpu_pkg::COUNT_W-1:0]           fault_count
);

  localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);

  logic [PAGE_BITS-1:0] frame_page [FRAMES];
  logic [FRAMES-1:0]    frame_valid;
  logic [FRAMES-1:0]    ref_bit;
  logic [SLOT_W-1:0]    hand;
  logic [crpu_pkg::COUNT_W-1:0] faults;

  logic [PAGE_BITS-1:0] page_q;
  logic                 res_hit;
  logic [SLOT_W-1:0]    res_slot;
  logic                 res_ev_valid;
  logic [PAGE_BITS-1:0] res_ev_page;

  logic [CNT_W-1:0]  n;
  logic [FRAMES-1:0] match;
  logic              hit_found;
  logic [SLOT_W-1:0] hit_idx;
  logic [CNT_W-1:0]  hand_ext;
  logic [CNT_W-1:0]  hand_inc;
  logic [SLOT_W-1:0] hand_step;
  logic              place_now;

  // Managed frame count: zero reads as one, clamp at the built count
  always_comb begin
    if (frames_in_use == '0) begin
      n = CNT_W'(1);
    end else if (32'(frames_in_use) > 32'(FRAMES)) begin
      n = CNT_W'(FRAMES);
    end else begin
      n = CNT_W'(frames_in_use);
    end
  end

  // Parallel lookup, lowest matching frame wins
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = frame_valid[i] && (frame_page[i] == page_q) && (CNT_W'(i) < n);
    end
    hit_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = SLOT_W'(i);
    end
    hit_found = |match;
  end

  always_comb begin
    hand_ext  = CNT_W'(hand);
    hand_inc  = hand_ext + CNT_W'(1);
    hand_step = (hand_inc >= n) ? '0 : SLOT_W'(hand_inc);
    place_now = !(frame_valid[hand] && ref_bit[hand]);
  end

  assign status.hit_found = hit_found;
  assign status.place_now = place_now;
  assign status.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      ref_bit     <= '0;
      hand        <= '0;
      faults      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.lookup) begin
        if (hit_found) begin
          ref_bit[hit_idx] <= 1'b1;
        end else begin
          if (faults != crpu_pkg::COUNT_MAX) faults <= faults + 1'b1;
          if (hand_ext >= n) hand <= '0;
        end
      end
      if (cmd.sweep) begin
        hand <= hand_step;
        if (place_now) begin
          frame_valid[hand] <= 1'b1;
          ref_bit[hand]     <= 1'b1;
        end else begin
          ref_bit[hand] <= 1'b0;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) page_q <= PAGE_BITS'(page_number);
    if (cmd.lookup && hit_found) begin
      res_hit      <= 1'b1;
      res_slot     <= hit_idx;
      res_ev_valid <= 1'b0;
      res_ev_page  <= '0;
    end
    if (cmd.sweep && place_now) begin
      frame_page[hand] <= page_q;
      res_hit          <= 1'b0;
      res_slot         <= hand;
      res_ev_valid     <= frame_valid[hand];
      res_ev_page      <= frame_valid[hand] ? frame_page[hand] : '0;
    end
    if (cmd.load_out) begin
      hit           <= res_hit;
      frame_slot    <= crpu_pkg::SLOT_PORT_W'(res_slot);
      evicted_valid <= res_ev_valid;
      evicted_page  <= crpu_pkg::PAGE_PORT_W'(res_ev_page);
      fault_count   <= faults;
    end
  end

  `CRPU_ASSERT_NEXT(a_load_shows, clk, rst, cmd.load_out, out_valid)
  `CRPU_ASSERT_NEXT(a_fault_counts, clk, rst,
    cmd.lookup && !hit_found && faults != crpu_pkg::COUNT_MAX,
    faults == $past(faults) + 1'b1)
  `CRPU_ASSERT_NEXT(a_hand_in_range, clk, rst, cmd.lookup && !hit_found, CNT_W'(hand) < n)
  `CRPU_ASSERT_NEXT(a_place_slot, clk, rst, cmd.sweep && place_now,
    !res_hit && res_slot == $past(hand))

endmodule
`default_nettype wire

// ===== hdl/clock_page_replacement_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake          | Payload
// ---------+--------------------+---------------------------------------------------
// input    | in_valid/in_stall  | page_number
// output   | out_valid/out_stall| hit, frame_slot, evicted_valid, evicted_page,
//          |                    | fault_count
// config   | APB (psel/penable) | frames_in_use at address 0
//
// One reference at a time. A hit passes capture, parallel compare and load on its
// way to the result register. A miss passes capture, compare, a sweep in which the
// hand clears 0..n reference bits before it places the page, and load; the hand visits
// one frame per cycle. rst is synchronous and empties all frames, hand and fault count.
// A stalled result holds in the output register; the next reference is taken
// once the previous result has been loaded there.
module clock_page_replacement_unit #(
  parameter int FRAMES    = crpu_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = crpu_pkg::PAGE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [crpu_pkg::PAGE_PORT_W-1:0]    page_number,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     hit,
  output logic [crpu_pkg::SLOT_PORT_W-1:0]         frame_slot,
  output logic                                     evicted_valid,
  output logic [crpu_pkg::PAGE_PORT_W-1:0]         evicted_page,
  output logic [crpu_pkg::COUNT_W-1:0]             fault_count,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [crpu_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [crpu_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [crpu_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                     pready
);

  logic [crpu_pkg::CFG_W-1:0] frames_in_use;
  crpu_pkg::cmd_t             cmd;
  crpu_pkg::status_t          status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= crpu_pkg::CFG_FRAMES_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == crpu_pkg::REG_FRAMES_IN_USE) begin
      frames_in_use <= pwdata[crpu_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == crpu_pkg::REG_FRAMES_IN_USE) begin
      prdata = crpu_pkg::APB_DATA_W'(frames_in_use);
    end
  end

  crpu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  crpu_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .frames_in_use (frames_in_use),
    .page_number   (page_number),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .frame_slot    (frame_slot),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count)
  );

endmodule
`default_nettype wire
